// File: rtl/core/ole_pkg.sv
package ole_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 8;
  localparam int POS_W = 6;
  localparam int LEN_W = 6;
  localparam int EXT_W = 8;

  typedef enum logic [2:0] {
    CMD_CLEAR      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_SEARCH     = 3'd5,
    CMD_REVERSE    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_DELETE,
    MODE_MIRROR,
    MODE_SHIFT
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REVERSE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic               search_start;
    logic               scan_shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic               last;
    logic [LEN_W-1:0]   length;
    logic [POS_W-1:0]   found_position;
    status_t            status;
  } result_t;

endpackage

// File: rtl/core/ole_cell.sv
module ole_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ole_pkg::IDX_W-1:0] index,
  input  ole_pkg::cell_ctrl_t       ctrl,
  input  logic [ole_pkg::VAL_W-1:0] left_data,
  input  logic [ole_pkg::VAL_W-1:0] right_data,
  input  logic [ole_pkg::VAL_W-1:0] mirror_data,
  input  logic                      right_flag,
  output logic [ole_pkg::VAL_W-1:0] data,
  output logic                      flag
);
  import ole_pkg::*;

  logic [VAL_W-1:0] data_next;
  logic             in_list;

  assign in_list = CNT_W'(index) < ctrl.count;

  always_comb begin
    data_next = data;
    case (ctrl.mode)
      MODE_INSERT: begin
        if (index == ctrl.idx) begin
          data_next = ctrl.value;
        end else if (index > ctrl.idx) begin
          data_next = left_data;
        end
      end
      MODE_DELETE: begin
        if (index >= ctrl.idx) begin
          data_next = right_data;
        end
      end
      MODE_MIRROR: data_next = mirror_data;
      MODE_SHIFT:  data_next = right_data;
      default:     data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.search_start) begin
      flag <= in_list && (data == ctrl.value);
    end else if (ctrl.scan_shift) begin
      flag <= right_flag;
    end
  end

endmodule

// File: rtl/core/ole_chain.sv
module ole_chain (
  input  logic                      clk,
  input  logic                      rst,
  input  ole_pkg::cell_ctrl_t       ctrl,
  output logic [ole_pkg::DEPTH-1:0] flags
);
  import ole_pkg::*;

  logic [VAL_W-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;
    logic             right_f;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
      assign right_f = 1'b0;
    end else begin : g_inner_r
      assign right_d = data[i+1];
      assign right_f = flags[i+1];
    end

    ole_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .index       (IDX_W'(i)),
      .ctrl        (ctrl),
      .left_data   (left_d),
      .right_data  (right_d),
      .mirror_data (data[DEPTH-1-i]),
      .right_flag  (right_f),
      .data        (data[i]),
      .flag        (flags[i])
    );
  end

endmodule

// File: rtl/core/ordered_list_engine.sv
// Ordered byte list held in a chain of cells, one entry per cell, front at cell 0.
// One command per s_ transfer. Clear, push front, push back, insert and delete
// act on the whole chain at once: every cell loads, holds or takes a neighbor's
// entry. Reverse mirrors the whole chain, then shifts it toward the front one
// cell per cycle, DEPTH - length cells in all. Search first marks the matching
// cells, then walks the match marks one cell per cycle up to the last match,
// giving one result per match (one not-found result if none); this walk pauses
// while the result queue is full. Results go through a two-entry queue, so
// m_tready low stalls the block only once two results wait.
module ordered_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // cmd[2:0], value[10:3], position[16:11], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[1:0], found_position[7:2], length[13:8], zero fill
  output logic        m_tlast
);
  import ole_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rev_left, rev_left_next;
  logic [CNT_W-1:0]  scan_pos, scan_pos_next;
  logic [DEPTH-1:0]  flags;
  cell_ctrl_t        ctrl;

  result_t           out_q, skid_q, res;
  logic              out_valid, skid_valid;
  logic              push, pop, can_push, accept;

  cmd_t              in_cmd;
  logic [VAL_W-1:0]  in_value;
  logic [POS_W-1:0]  in_pos;
  logic [EXT_W-1:0]  pos_ext, cnt_ext;
  logic              full, rest_zero;

  assign in_cmd   = cmd_t'(s_tdata[2:0]);
  assign in_value = s_tdata[10:3];
  assign in_pos   = s_tdata[16:11];
  assign pos_ext  = EXT_W'(in_pos);
  assign cnt_ext  = EXT_W'(count);
  assign full     = count == CNT_W'(DEPTH);
  assign rest_zero = (flags >> 1) == '0;

  assign can_push = !skid_valid;
  assign s_tready = (state == ST_IDLE) && !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_q.length, out_q.found_position, out_q.status};
  assign m_tlast  = out_q.last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_SEARCH) begin
          state_next = ST_SCAN;
        end else if (accept && in_cmd == CMD_REVERSE && !full) begin
          state_next = ST_REVERSE;
        end
      end
      ST_REVERSE: begin
        if (rev_left == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (can_push && (flags == '0 || (flags[0] && rest_zero))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.mode         = MODE_HOLD;
    ctrl.idx          = '0;
    ctrl.value        = in_value;
    ctrl.count        = count;
    ctrl.search_start = 1'b0;
    ctrl.scan_shift   = 1'b0;
    count_next        = count;
    rev_left_next     = rev_left;
    scan_pos_next     = scan_pos;
    push              = 1'b0;
    res.status        = STAT_OK;
    res.found_position = '0;
    res.last          = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          push = 1'b1;
          case (in_cmd)
            CMD_CLEAR: count_next = '0;
            CMD_PUSH_FRONT: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctrl.mode  = MODE_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctrl.mode  = MODE_INSERT;
                ctrl.idx   = IDX_W'(count);
                count_next = count + CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              if (in_pos == '0 || pos_ext > cnt_ext + EXT_W'(1)) begin
                res.status = STAT_RANGE;
              end else if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctrl.mode  = MODE_INSERT;
                ctrl.idx   = IDX_W'(pos_ext - EXT_W'(1));
                count_next = count + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (in_pos == '0 || pos_ext > cnt_ext) begin
                res.status = STAT_RANGE;
              end else begin
                ctrl.mode  = MODE_DELETE;
                ctrl.idx   = IDX_W'(pos_ext - EXT_W'(1));
                count_next = count - CNT_W'(1);
              end
            end
            CMD_SEARCH: begin
              push              = 1'b0;
              ctrl.search_start = 1'b1;
              scan_pos_next     = '0;
            end
            CMD_REVERSE: begin
              ctrl.mode     = MODE_MIRROR;
              rev_left_next = CNT_W'(DEPTH) - count;
            end
            default: push = 1'b1;
          endcase
        end
      end
      ST_REVERSE: begin
        ctrl.mode     = MODE_SHIFT;
        rev_left_next = rev_left - CNT_W'(1);
      end
      ST_SCAN: begin
        if (can_push) begin
          ctrl.scan_shift = 1'b1;
          scan_pos_next   = scan_pos + CNT_W'(1);
          if (flags == '0) begin
            push       = 1'b1;
            res.status = STAT_NOT_FOUND;
          end else if (flags[0]) begin
            push               = 1'b1;
            res.found_position = POS_W'(scan_pos + CNT_W'(1));
            res.last           = rest_zero;
          end
        end
      end
      default: ctrl.mode = MODE_HOLD;
    endcase
    res.length = LEN_W'(count_next);
  end

  ole_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rev_left <= '0;
      scan_pos <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rev_left <= rev_left_next;
      scan_pos <= scan_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= push;
    end else if (pop) begin
      out_valid  <= push;
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_q <= skid_q;
      if (push) begin
        skid_q <= res;
      end
    end else if (pop) begin
      if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("list length beyond depth");

  a_rev_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_REVERSE |-> rev_left != '0)
    else $error("reverse shift with nothing left to shift");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_cmd != CMD_SEARCH |=> m_tvalid)
    else $error("command transfer produced no result");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

endmodule
